// ===== src/rcis_pkg.sv =====
// Shared types and constants for the reference-counted identifier set.
package rcis_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int DEFAULT_KEY_WIDTH   = 16;

	localparam int OPC_W  = 2;
	localparam int SKEY_W = 16;
	localparam int AMT_W  = 15;
	localparam int CNT_W  = 16;
	localparam int OCC_W  = 7;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	localparam logic [OPC_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OPC_W-1:0] OP_SUB   = 2'd1;
	localparam logic [OPC_W-1:0] OP_QUERY = 2'd2;

	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

	// Search word that moves down the cell chain, one cell per cycle.
	typedef struct packed {
		logic vld;
		logic hit;
		logic free;
	} tok_flags_t;

	// Write command broadcast from the controller to the cells.
	typedef struct packed {
		logic en;
		logic set_valid;
		logic clr_valid;
	} wr_flags_t;

endpackage

// ===== src/rcis_cell.sv =====
// One table entry with its stage of the search chain.
module rcis_cell #(
	parameter int TABLE_DEPTH = rcis_pkg::DEFAULT_TABLE_DEPTH,
	parameter int KEY_WIDTH   = rcis_pkg::DEFAULT_KEY_WIDTH,
	parameter int IDX         = 0,
	localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rcis_pkg::tok_flags_t              tok_in,
	input  logic [IDX_W-1:0]                  hit_idx_in,
	input  logic signed [rcis_pkg::CNT_W-1:0] hit_cnt_in,
	input  logic [IDX_W-1:0]                  free_idx_in,
	input  logic [KEY_WIDTH-1:0]              key,
	input  rcis_pkg::wr_flags_t               wr,
	input  logic [IDX_W-1:0]                  wr_idx,
	input  logic [KEY_WIDTH-1:0]              wr_key,
	input  logic signed [rcis_pkg::CNT_W-1:0] wr_cnt,
	output rcis_pkg::tok_flags_t              tok_out,
	output logic [IDX_W-1:0]                  hit_idx_out,
	output logic signed [rcis_pkg::CNT_W-1:0] hit_cnt_out,
	output logic [IDX_W-1:0]                  free_idx_out
);

	logic                              ent_vld_q;
	logic [KEY_WIDTH-1:0]              ent_key_q;
	logic signed [rcis_pkg::CNT_W-1:0] ent_cnt_q;

	rcis_pkg::tok_flags_t              tok_q;
	logic [IDX_W-1:0]                  hidx_q;
	logic signed [rcis_pkg::CNT_W-1:0] hcnt_q;
	logic [IDX_W-1:0]                  fidx_q;

	rcis_pkg::tok_flags_t              tok_nx;
	logic [IDX_W-1:0]                  hidx_nx;
	logic signed [rcis_pkg::CNT_W-1:0] hcnt_nx;
	logic [IDX_W-1:0]                  fidx_nx;
	logic                              sel;

	assign sel = wr.en && (wr_idx == IDX_W'(IDX));

	// Only the first matching entry and the first free entry are recorded.
	always_comb begin
		tok_nx  = tok_in;
		hidx_nx = hit_idx_in;
		hcnt_nx = hit_cnt_in;
		fidx_nx = free_idx_in;
		if (ent_vld_q && (ent_key_q == key) && !tok_in.hit) begin
			tok_nx.hit = 1'b1;
			hidx_nx    = IDX_W'(IDX);
			hcnt_nx    = ent_cnt_q;
		end
		if (!ent_vld_q && !tok_in.free) begin
			tok_nx.free = 1'b1;
			fidx_nx     = IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q <= tok_nx;
			if (sel && wr.set_valid) begin
				ent_vld_q <= 1'b1;
			end else if (sel && wr.clr_valid) begin
				ent_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hidx_q <= hidx_nx;
		hcnt_q <= hcnt_nx;
		fidx_q <= fidx_nx;
		if (sel) begin
			ent_key_q <= wr_key;
			ent_cnt_q <= wr_cnt;
		end
	end

	assign tok_out      = tok_q;
	assign hit_idx_out  = hidx_q;
	assign hit_cnt_out  = hcnt_q;
	assign free_idx_out = fidx_q;

endmodule

// ===== src/ref_counted_id_set.sv =====
// Top level of the reference-counted identifier set: cell chain and controller.
//
// Channel  Direction  Word contents (lowest bit first)
// s_*      in         opcode[1:0], spawn_key[17:2], amount[32:18], zero fill to 40 bits
// m_*      out        was_present[0], membership_changed[1], table_full[2],
//                     count_after[18:3], occupancy[25:19], zero fill to 32 bits
//
// After acceptance the search word passes through the table cells, one cell per cycle;
// the controller then collects it and, once the output can take a word, applies the
// update and loads the output register.
// Reset empties the table at once; there is no clearing pass.
// A new word is accepted once the previous result is in the output register, so a
// stalled output holds only the following item at its last step.
module ref_counted_id_set #(
	parameter int TABLE_DEPTH = rcis_pkg::DEFAULT_TABLE_DEPTH,
	parameter int KEY_WIDTH   = rcis_pkg::DEFAULT_KEY_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rcis_pkg::S_TDATA_W-1:0]   s_tdata,  // opcode, spawn_key, amount
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rcis_pkg::M_TDATA_W-1:0]   m_tdata   // was_present, membership_changed,
	                                                   // table_full, count_after, occupancy
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int OCC_CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CW = rcis_pkg::CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [rcis_pkg::OPC_W-1:0] op_q;
	logic [rcis_pkg::AMT_W-1:0] amt_q;
	logic [KEY_WIDTH-1:0]       key_q;
	logic [KEY_WIDTH-1:0]       key_in;
	logic [31:0]                key_ext;
	logic                       start_q;

	logic                  hit_q;
	logic                  free_q;
	logic [IDX_W-1:0]      hidx_q;
	logic signed [CW-1:0]  hcnt_q;
	logic [IDX_W-1:0]      fidx_q;
	logic [OCC_CNT_W-1:0]  occ_q;

	logic [rcis_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                           m_tvalid_q;

	rcis_pkg::tok_flags_t  tok_f   [TABLE_DEPTH+1];
	logic [IDX_W-1:0]      tok_hidx[TABLE_DEPTH+1];
	logic signed [CW-1:0]  tok_hcnt[TABLE_DEPTH+1];
	logic [IDX_W-1:0]      tok_fidx[TABLE_DEPTH+1];

	rcis_pkg::wr_flags_t   wr;
	logic [IDX_W-1:0]      wr_idx;
	logic signed [CW-1:0]  wr_cnt;

	logic                  accept;
	logic                  fire;
	logic signed [CW:0]    sum_w;
	logic signed [CW:0]    diff_w;
	logic signed [CW-1:0]  sum_sat;
	logic signed [CW-1:0]  diff_sat;
	logic signed [CW-1:0]  after;
	logic                  changed;
	logic                  full;
	logic                  occ_inc;
	logic                  occ_dec;
	logic [OCC_CNT_W-1:0]  occ_nx;
	logic [31:0]           occ_ext;
	logic [rcis_pkg::OCC_W-1:0] occ_out;

	assign key_ext = {16'b0, s_tdata[17:2]};
	assign key_in  = key_ext[KEY_WIDTH-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign fire     = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// The search starts in the cycle after acceptance, once the key register holds the new key.
	assign tok_f[0]    = '{vld: start_q, hit: 1'b0, free: 1'b0};
	assign tok_hidx[0] = '0;
	assign tok_hcnt[0] = '0;
	assign tok_fidx[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		rcis_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.KEY_WIDTH  (KEY_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_in      (tok_f[i]),
			.hit_idx_in  (tok_hidx[i]),
			.hit_cnt_in  (tok_hcnt[i]),
			.free_idx_in (tok_fidx[i]),
			.key         (key_q),
			.wr          (wr),
			.wr_idx      (wr_idx),
			.wr_key      (key_q),
			.wr_cnt      (wr_cnt),
			.tok_out     (tok_f[i+1]),
			.hit_idx_out (tok_hidx[i+1]),
			.hit_cnt_out (tok_hcnt[i+1]),
			.free_idx_out(tok_fidx[i+1])
		);
	end

	// Saturating count arithmetic on one extra bit.
	always_comb begin
		sum_w  = {hcnt_q[CW-1], hcnt_q} + $signed({2'b00, amt_q});
		diff_w = {hcnt_q[CW-1], hcnt_q} - $signed({2'b00, amt_q});
		sum_sat  = (sum_w > $signed({1'b0, rcis_pkg::CNT_MAX})) ? rcis_pkg::CNT_MAX
		                                                         : sum_w[CW-1:0];
		diff_sat = (diff_w < $signed({1'b1, rcis_pkg::CNT_MIN})) ? rcis_pkg::CNT_MIN
		                                                          : diff_w[CW-1:0];
	end

	always_comb begin
		wr      = '0;
		wr_idx  = hidx_q;
		wr_cnt  = '0;
		after   = hit_q ? hcnt_q : '0;
		changed = 1'b0;
		full    = 1'b0;
		occ_inc = 1'b0;
		occ_dec = 1'b0;
		case (op_q)
			rcis_pkg::OP_ADD: begin
				if (hit_q) begin
					after  = sum_sat;
					wr.en  = 1'b1;
					wr_cnt = sum_sat;
				end else if (free_q) begin
					after        = $signed({1'b0, amt_q});
					wr.en        = 1'b1;
					wr.set_valid = 1'b1;
					wr_idx       = fidx_q;
					wr_cnt       = $signed({1'b0, amt_q});
					changed      = 1'b1;
					occ_inc      = 1'b1;
				end else begin
					after = '0;
					full  = 1'b1;
				end
			end
			rcis_pkg::OP_SUB: begin
				if (hit_q) begin
					after  = diff_sat;
					wr.en  = 1'b1;
					wr_cnt = diff_sat;
					if (diff_sat == '0) begin
						wr.clr_valid = 1'b1;
						changed      = 1'b1;
						occ_dec      = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		wr.en = wr.en && fire;
		occ_nx = occ_q;
		if (fire && occ_inc) begin
			occ_nx = occ_q + 1'b1;
		end else if (fire && occ_dec) begin
			occ_nx = occ_q - 1'b1;
		end
		occ_ext = 32'(occ_nx);
		occ_out = (occ_ext > 32'd127) ? 7'd127 : occ_ext[rcis_pkg::OCC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			occ_q      <= '0;
			start_q    <= 1'b0;
		end else begin
			occ_q   <= occ_nx;
			start_q <= accept;
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_f[TABLE_DEPTH].vld) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tdata[1:0];
			key_q <= key_in;
			amt_q <= s_tdata[32:18];
		end
		if (state_q == ST_SCAN && tok_f[TABLE_DEPTH].vld) begin
			hit_q  <= tok_f[TABLE_DEPTH].hit;
			free_q <= tok_f[TABLE_DEPTH].free;
			hidx_q <= tok_hidx[TABLE_DEPTH];
			hcnt_q <= tok_hcnt[TABLE_DEPTH];
			fidx_q <= tok_fidx[TABLE_DEPTH];
		end
		if (fire) begin
			m_tdata_q <= {6'b0, occ_out, after, full, changed, hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== src/rcis_checker.sv =====
// Port-level checks for the reference-counted identifier set, bound to the top level.
module rcis_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rcis_pkg::M_TDATA_W-1:0] m_tdata
);

	// Only one item is in flight, so the input closes right after a word is taken.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input stayed open after accepting a word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	// A dropped insert leaves nothing behind.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1] && (m_tdata[18:3] == 16'd0))
		else $error("table_full result carries a count or flags");

	// An absent key that was not inserted reports a zero count.
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] && !m_tdata[1] |-> (m_tdata[18:3] == 16'd0))
		else $error("absent key reported a nonzero count");

	// A removal always reports a zero count.
	a_remove_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] && m_tdata[1] |-> (m_tdata[18:3] == 16'd0))
		else $error("removed entry reported a nonzero count");

endmodule

bind ref_counted_id_set rcis_checker u_rcis_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
